// ----- rtl/hus_pkg.sv -----
// Shared types, codes and constants for the HTTP URL splitter.
package hus_pkg;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
  localparam int          QUEUE_DEPTH      = 4;

  localparam logic [2:0]  PREFIX_LEN = 3'd7;
  localparam logic [16:0] PORT_LIMIT = 17'd65535;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] KIND_HOST    = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
  localparam logic [2:0] ST_EMPTY_HOST = 3'd2;
  localparam logic [2:0] ST_BAD_PORT   = 3'd3;
  localparam logic [2:0] ST_PORT_LARGE = 3'd4;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_HOST   = 3'd1,
    PH_PORT   = 3'd2,
    PH_PATH   = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SUB_LEAD   = 2'd0,
    SUB_SIGN   = 2'd1,
    SUB_DIGITS = 2'd2
  } subphase_t;

  // One queue entry: everything one input byte causes on the result side.
  typedef struct packed {
    logic        has_char;
    logic [1:0]  char_kind;
    logic [7:0]  char_val;
    logic        has_slash;
    logic        has_sum;
    logic [2:0]  status;
    logic [16:0] port;
  } q_entry_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h70;
      3'd4:    ch = CH_COLON;
      3'd5:    ch = CH_SLASH;
      3'd6:    ch = CH_SLASH;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/http_url_splitter.sv -----
// Top level of the HTTP URL splitter: front end, queue and back end.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_char_code, in_last_char
//   out_     output     out_valid/out_stall out_item_kind, out_char_value, out_status,
//                                          out_port_value, out_last_of_url
//   cfg_     input      cfg_write_en       cfg_write_data (default port)
//
// One byte is taken per cycle while in_stall is low; each result leaves the output
// register one per cycle while out_stall is low. A byte that ends a URL causes up to
// three results, so the back end drains them one at a time while the queue keeps
// taking bytes until it fills. Results pass through the queue and the output register.
// Reset is synchronous and active low; the default port returns to 80.
// in_stall is high only while the queue between front and back end is full.
module http_url_splitter
  import hus_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_char_value,
  output logic [2:0]         out_status,
  output logic signed [16:0] out_port_value,
  output logic               out_last_of_url,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data
);

  q_entry_t push_data;
  q_entry_t head;
  logic     push, pop, full, empty;

  hus_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_full         (full),
    .q_push         (push),
    .q_data         (push_data)
  );

  hus_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  hus_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (empty),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_kind   (out_item_kind),
    .out_char_value  (out_char_value),
    .out_status      (out_status),
    .out_port_value  (out_port_value),
    .out_last_of_url (out_last_of_url)
  );

endmodule

// ----- rtl/hus_front.sv -----
// Front end: takes URL bytes, tracks the parse and queues the results they cause.
module hus_front
  import hus_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_code,
  input  logic             in_last_char,
  input  logic             cfg_write_en,
  input  logic [15:0]      cfg_write_data,
  input  logic             q_full,
  output logic             q_push,
  output q_entry_t         q_data
);

  logic [15:0] default_port_r;
  logic [2:0]  prefix_count_r, prefix_count_nxt;
  phase_t      phase_r, phase_nxt;
  logic        prefix_failed_r, prefix_failed_nxt;
  logic        host_seen_r, host_seen_nxt;
  logic        text_seen_r, text_seen_nxt;
  subphase_t   sub_r, sub_nxt;
  logic        negative_r, negative_nxt;
  logic        digits_seen_r, digits_seen_nxt;
  logic        bad_text_r, bad_text_nxt;
  logic        too_large_r, too_large_nxt;
  logic [16:0] accum_r, accum_nxt;

  logic        accept;
  logic        is_ws, is_sign, is_digit;
  logic [20:0] accum_ext;
  logic        prefix_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_ws    = (in_char_code == CH_SPACE) ||
                    ((in_char_code >= CH_TAB) && (in_char_code <= CH_CR));
  assign is_sign  = (in_char_code == CH_PLUS) || (in_char_code == CH_MINUS);
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  // accum * 10 + digit, by shift and add
  assign accum_ext = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
                     + {17'd0, in_char_code[3:0]};

  always_comb begin
    prefix_count_nxt  = prefix_count_r;
    phase_nxt         = phase_r;
    prefix_failed_nxt = prefix_failed_r;
    host_seen_nxt     = host_seen_r;
    text_seen_nxt     = text_seen_r;
    sub_nxt           = sub_r;
    negative_nxt      = negative_r;
    digits_seen_nxt   = digits_seen_r;
    bad_text_nxt      = bad_text_r;
    too_large_nxt     = too_large_r;
    accum_nxt         = accum_r;
    q_data            = '0;
    q_data.char_val   = in_char_code;

    unique case (phase_r)
      PH_PREFIX: begin
        if (in_char_code == prefix_char(prefix_count_r)) begin
          prefix_count_nxt = prefix_count_r + 3'd1;
          if (prefix_count_r == PREFIX_LEN - 3'd1) phase_nxt = PH_HOST;
        end else begin
          prefix_failed_nxt = 1'b1;
          phase_nxt         = PH_SKIP;
        end
      end
      PH_HOST: begin
        if (in_char_code == CH_SLASH) begin
          phase_nxt        = PH_PATH;
          q_data.has_char  = 1'b1;
          q_data.char_kind = KIND_PATH;
        end else if (in_char_code == CH_COLON) begin
          phase_nxt = PH_PORT;
        end else begin
          host_seen_nxt    = 1'b1;
          q_data.has_char  = 1'b1;
          q_data.char_kind = KIND_HOST;
        end
      end
      PH_PORT: begin
        if (in_char_code == CH_SLASH) begin
          phase_nxt        = PH_PATH;
          q_data.has_char  = 1'b1;
          q_data.char_kind = KIND_PATH;
        end else if (in_char_code != CH_COLON) begin
          text_seen_nxt = 1'b1;
          if (!bad_text_r) begin
            priority if (sub_r == SUB_LEAD && is_ws) begin
              // skip leading blanks
            end else if (sub_r == SUB_LEAD && is_sign) begin
              negative_nxt = (in_char_code == CH_MINUS);
              sub_nxt      = SUB_SIGN;
            end else if (!is_digit) begin
              bad_text_nxt = 1'b1;
            end else begin
              sub_nxt         = SUB_DIGITS;
              digits_seen_nxt = 1'b1;
              if (accum_ext > {4'd0, PORT_LIMIT}) begin
                too_large_nxt = 1'b1;
                accum_nxt     = PORT_LIMIT + 17'd1;
              end else begin
                accum_nxt = accum_ext[16:0];
              end
            end
          end
        end
      end
      PH_PATH: begin
        q_data.has_char  = 1'b1;
        q_data.char_kind = KIND_PATH;
      end
      default: begin
      end
    endcase

    // End of URL: default path, summary, and a fresh parse state.
    prefix_ok = !prefix_failed_nxt && (phase_nxt != PH_PREFIX);
    if (in_last_char) begin
      q_data.has_sum   = 1'b1;
      q_data.has_slash = prefix_ok && (phase_nxt != PH_PATH);
      priority if (!prefix_ok)
        q_data.status = ST_BAD_PREFIX;
      else if (!host_seen_nxt)
        q_data.status = ST_EMPTY_HOST;
      else if (text_seen_nxt && (bad_text_nxt || !digits_seen_nxt))
        q_data.status = ST_BAD_PORT;
      else if (text_seen_nxt && too_large_nxt)
        q_data.status = ST_PORT_LARGE;
      else
        q_data.status = ST_OK;
      if (q_data.status == ST_OK) begin
        if (text_seen_nxt)
          q_data.port = negative_nxt ? (17'd0 - accum_nxt) : accum_nxt;
        else
          q_data.port = {1'b0, default_port_r};
      end
      prefix_count_nxt  = '0;
      phase_nxt         = PH_PREFIX;
      prefix_failed_nxt = 1'b0;
      host_seen_nxt     = 1'b0;
      text_seen_nxt     = 1'b0;
      sub_nxt           = SUB_LEAD;
      negative_nxt      = 1'b0;
      digits_seen_nxt   = 1'b0;
      bad_text_nxt      = 1'b0;
      too_large_nxt     = 1'b0;
      accum_nxt         = '0;
    end
  end

  // drop bytes that cause no result
  assign q_push = accept && (q_data.has_char || q_data.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r  <= DEFAULT_PORT_RST;
      prefix_count_r  <= '0;
      phase_r         <= PH_PREFIX;
      prefix_failed_r <= 1'b0;
      host_seen_r     <= 1'b0;
      text_seen_r     <= 1'b0;
      sub_r           <= SUB_LEAD;
      negative_r      <= 1'b0;
      digits_seen_r   <= 1'b0;
      bad_text_r      <= 1'b0;
      too_large_r     <= 1'b0;
      accum_r         <= '0;
    end else begin
      if (cfg_write_en) default_port_r <= cfg_write_data;
      if (accept) begin
        prefix_count_r  <= prefix_count_nxt;
        phase_r         <= phase_nxt;
        prefix_failed_r <= prefix_failed_nxt;
        host_seen_r     <= host_seen_nxt;
        text_seen_r     <= text_seen_nxt;
        sub_r           <= sub_nxt;
        negative_r      <= negative_nxt;
        digits_seen_r   <= digits_seen_nxt;
        bad_text_r      <= bad_text_nxt;
        too_large_r     <= too_large_nxt;
        accum_r         <= accum_nxt;
      end
    end
  end

endmodule

// ----- rtl/hus_fifo.sv -----
// Short queue between the front and back ends.
module hus_fifo
  import hus_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output logic     full,
  output logic     empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == FullCnt);
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt) else $error("queue count out of range");

endmodule

// ----- rtl/hus_back.sv -----
// Back end: expands queued entries into result transactions, one per cycle while out_stall is low.
module hus_back
  import hus_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  q_entry_t           head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_char_value,
  output logic [2:0]         out_status,
  output logic signed [16:0] out_port_value,
  output logic               out_last_of_url
);

  logic [2:0]  done_r, done_nxt;
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  char_r, char_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [16:0] port_r, port_nxt;
  logic        last_r, last_nxt;

  logic [2:0]  pending;
  logic [2:0]  sel;
  logic        load;

  assign pending = q_empty ? 3'b000
                 : ({head.has_sum, head.has_slash, head.has_char} & ~done_r);
  assign load    = (!out_valid_r || !out_stall) && (pending != 3'b000);

  always_comb begin
    sel        = 3'b000;
    kind_nxt   = KIND_SUMMARY;
    char_nxt   = '0;
    status_nxt = ST_OK;
    port_nxt   = '0;
    last_nxt   = 1'b0;
    priority if (pending[0]) begin
      sel      = 3'b001;
      kind_nxt = head.char_kind;
      char_nxt = head.char_val;
    end else if (pending[1]) begin
      sel      = 3'b010;
      kind_nxt = KIND_PATH;
      char_nxt = CH_SLASH;
    end else begin
      sel        = 3'b100;
      status_nxt = head.status;
      port_nxt   = head.port;
      last_nxt   = 1'b1;
    end
    // pop once the last pending result of the entry leaves
    q_pop    = load && ((pending & ~sel) == 3'b000);
    done_nxt = done_r;
    if (load) done_nxt = q_pop ? 3'b000 : (done_r | sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (load)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      char_r   <= char_nxt;
      status_r <= status_nxt;
      port_r   <= port_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = kind_r;
  assign out_char_value  = char_r;
  assign out_status      = status_r;
  assign out_port_value  = $signed(port_r);
  assign out_last_of_url = last_r;

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((kind_r == KIND_SUMMARY) == last_r))
    else $error("last flag does not match summary kind");
  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (status_r == ST_OK && port_r == '0))
    else $error("character result carries summary fields");

endmodule
